// File: rtl/sample_buffer_timestamper_unit_defines.svh
// ----------------------------------------------------------------------------
// Sample buffer timestamper assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_BUFFER_TIMESTAMPER_UNIT_DEFINES_SVH
`define SAMPLE_BUFFER_TIMESTAMPER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define SBTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never hold outside reset
`define SBTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SBTS_ASSERT(lbl, prop, msg)
`define SBTS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/sbts_pkg.sv
// ----------------------------------------------------------------------------
// Sample buffer timestamper package
// Datapath widths, configuration constants, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package sbts_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 13;
  localparam int unsigned PcW   = 5;

  // Configuration register indexes
  localparam logic [1:0] CfgTicksPerSecond = 2'd0;
  localparam logic [1:0] CfgTicksPerSample = 2'd1;
  localparam logic [1:0] CfgTriggerDelay   = 2'd2;

  // Configuration reset values
  localparam logic [31:0] TpsReset   = 32'd60000000;
  localparam logic [15:0] TpsmReset  = 16'd60;
  localparam logic [15:0] TdReset    = 16'd2048;

  // Request kinds
  localparam logic [1:0] ReqStart   = 2'd0;
  localparam logic [1:0] ReqBufDone = 2'd1;
  localparam logic [1:0] ReqStop    = 2'd2;
  localparam logic [1:0] ReqUnknown = 2'd3;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_CLR,
    OP_DIV_ALIGN,
    OP_SYNC,
    OP_DIV_SPLIT,
    OP_SPLIT,
    OP_BUF_ADD,
    OP_BUF_WRAP,
    OP_POS,
    OP_MUL,
    OP_TADD,
    OP_TNEG,
    OP_TPOS,
    OP_EMIT
  } op_e;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    C_NEXT,     // fall through
    C_GOTO,     // unconditional jump
    C_NOACC,    // jump when no beat is taken
    C_REQ,      // jump to target plus request kind
    C_DIVBUSY,  // jump while the divider runs
    C_EMIT      // jump when the result slot is free, else hold
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic       accept;
    logic       div_busy;
    logic       out_free;
    logic [1:0] req;
  } status_t;

  // Program entry points
  localparam logic [PcW-1:0] PcIdle  = 5'd0;
  localparam logic [PcW-1:0] PcDisp  = 5'd2;
  localparam logic [PcW-1:0] PcStart = 5'd6;
  localparam logic [PcW-1:0] PcWaitA = 5'd7;
  localparam logic [PcW-1:0] PcWaitB = 5'd10;
  localparam logic [PcW-1:0] PcBufc  = 5'd12;
  localparam logic [PcW-1:0] PcStop  = 5'd14;
  localparam logic [PcW-1:0] PcEmit  = 5'd19;

  // Microcode program
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_GOTO, target: PcIdle};
    case (pc)
      5'd0:  w = '{op: OP_CAPTURE,   cond: C_NOACC,   target: PcIdle};
      5'd1:  w = '{op: OP_CLR,       cond: C_REQ,     target: PcDisp};
      5'd2:  w = '{op: OP_NOP,       cond: C_GOTO,    target: PcStart};
      5'd3:  w = '{op: OP_NOP,       cond: C_GOTO,    target: PcBufc};
      5'd4:  w = '{op: OP_NOP,       cond: C_GOTO,    target: PcStop};
      5'd5:  w = '{op: OP_NOP,       cond: C_GOTO,    target: PcEmit};
      5'd6:  w = '{op: OP_DIV_ALIGN, cond: C_NEXT,    target: PcIdle};
      5'd7:  w = '{op: OP_NOP,       cond: C_DIVBUSY, target: PcWaitA};
      5'd8:  w = '{op: OP_SYNC,      cond: C_NEXT,    target: PcIdle};
      5'd9:  w = '{op: OP_DIV_SPLIT, cond: C_NEXT,    target: PcIdle};
      5'd10: w = '{op: OP_NOP,       cond: C_DIVBUSY, target: PcWaitB};
      5'd11: w = '{op: OP_SPLIT,     cond: C_GOTO,    target: PcEmit};
      5'd12: w = '{op: OP_BUF_ADD,   cond: C_NEXT,    target: PcIdle};
      5'd13: w = '{op: OP_BUF_WRAP,  cond: C_GOTO,    target: PcEmit};
      5'd14: w = '{op: OP_POS,       cond: C_NEXT,    target: PcIdle};
      5'd15: w = '{op: OP_MUL,       cond: C_NEXT,    target: PcIdle};
      5'd16: w = '{op: OP_TADD,      cond: C_NEXT,    target: PcIdle};
      5'd17: w = '{op: OP_TNEG,      cond: C_NEXT,    target: PcIdle};
      5'd18: w = '{op: OP_TPOS,      cond: C_GOTO,    target: PcEmit};
      5'd19: w = '{op: OP_EMIT,      cond: C_EMIT,    target: PcIdle};
      default: w = '{op: OP_NOP,     cond: C_GOTO,    target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/sbts_div.sv
// ----------------------------------------------------------------------------
// Sample buffer timestamper divider
// Unsigned 32-bit restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sbts_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sbts_pkg::DataW-1:0]  dividend_i,
  input  logic [sbts_pkg::DataW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [sbts_pkg::DataW-1:0]  quotient_o,
  output logic [sbts_pkg::DataW-1:0]  remainder_o
);

  localparam int unsigned W     = sbts_pkg::DataW;
  localparam int unsigned Iters = W / 2;
  localparam int unsigned CntW  = $clog2(Iters);

  logic                busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [W-1:0]        rem_q, rem_d;
  logic [W-1:0]        quo_q, quo_d;
  logic [W-1:0]        dvs_q;
  logic [W:0]          r1, r2;
  logic                ge1, ge2;
  logic [W-1:0]        r1s;

  // Two dependent shift/compare/subtract steps
  always_comb begin
    r1    = {rem_q, quo_q[W-1]};
    ge1   = (r1 >= {1'b0, dvs_q});
    r1s   = ge1 ? W'(r1 - {1'b0, dvs_q}) : W'(r1);
    r2    = {r1s, quo_q[W-2]};
    ge2   = (r2 >= {1'b0, dvs_q});
    rem_d = ge2 ? W'(r2 - {1'b0, dvs_q}) : W'(r2);
    quo_d = {quo_q[W-3:0], ge1, ge2};
  end

  // Control: load on start, count down the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(Iters - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/sbts_seq.sv
// ----------------------------------------------------------------------------
// Sample buffer timestamper sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module sbts_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbts_pkg::status_t status_i,
  output sbts_pkg::ctrl_t   ctrl_o,
  output logic              idle_o
);

  localparam int unsigned PcW = sbts_pkg::PcW;

  logic [PcW-1:0]  pc_q, pc_d;
  sbts_pkg::ctrl_t ctrl;

  assign ctrl = sbts_pkg::ucode(pc_q);

  // Pick the next step
  always_comb begin
    pc_d = pc_q + 1'b1;
    case (ctrl.cond)
      sbts_pkg::C_NEXT:    pc_d = pc_q + 1'b1;
      sbts_pkg::C_GOTO:    pc_d = ctrl.target;
      sbts_pkg::C_NOACC:   pc_d = status_i.accept ? pc_q + 1'b1 : ctrl.target;
      sbts_pkg::C_REQ:     pc_d = ctrl.target + {{(PcW-2){1'b0}}, status_i.req};
      sbts_pkg::C_DIVBUSY: pc_d = status_i.div_busy ? ctrl.target : pc_q + 1'b1;
      sbts_pkg::C_EMIT:    pc_d = status_i.out_free ? ctrl.target : pc_q;
      default:             pc_d = sbts_pkg::PcIdle;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sbts_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign idle_o = (pc_q == sbts_pkg::PcIdle);

endmodule

// File: rtl/sample_buffer_timestamper_unit.sv
// ----------------------------------------------------------------------------
// Sample buffer timestamper unit
// Start: align and split divisions on the shared divider; buffer complete: add, wrap.
// Stop: position, multiply, add, borrow, carry; next beat the cycle after results load.
// Reset clears the buffer start time and loads the register defaults; no sweep.
// ----------------------------------------------------------------------------
`include "sample_buffer_timestamper_unit_defines.svh"

module sample_buffer_timestamper_unit #(
  parameter int unsigned BUF_SAMPLES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  // event channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        counter_now_i,
  input  logic [12:0]        dma_remaining_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        sync_tick_o,
  output logic [31:0]        buf_seconds_o,
  output logic [31:0]        buf_ticks_o,
  output logic [12:0]        stop_position_o,
  output logic [31:0]        trig_seconds_o,
  output logic signed [31:0] trig_ticks_o
);

  localparam int unsigned W    = sbts_pkg::DataW;
  localparam int unsigned PosW = sbts_pkg::PosW;
  localparam logic [W-1:0] BufSize = W'(BUF_SAMPLES);

  // Configuration registers
  logic [31:0] tps_q;
  logic [15:0] tpsm_q;
  logic [15:0] td_q;
  logic [W-1:0] len_q;

  // Captured event
  logic [1:0]      req_q;
  logic [W-1:0]    now_q;
  logic [PosW-1:0] rem_q;

  // Buffer start time
  logic [W-1:0] start_sec_q;
  logic [W-1:0] start_ticks_q;

  // Working and result registers
  logic [W-1:0]    acc_q;
  logic [W-1:0]    sync_q;
  logic [PosW-1:0] pos_q;
  logic [W-1:0]    tsec_q;
  logic [W-1:0]    ttk_q;

  // Output stage
  logic            out_valid_q;
  logic [W-1:0]    o_sync_q, o_bsec_q, o_btk_q, o_tsec_q, o_ttk_q;
  logic [PosW-1:0] o_pos_q;

  sbts_pkg::ctrl_t   ctrl;
  sbts_pkg::status_t status;
  logic              seq_idle;
  logic              accept;
  logic              out_free;

  logic              div_start;
  logic [W-1:0]      div_a, div_b, div_q, div_r;
  logic              div_busy;

  logic [W-1:0]      full_pos;

  assign accept   = in_valid_i && seq_idle;
  assign out_free = !out_valid_q || !out_stall_i;

  assign status = '{accept: accept, div_busy: div_busy, out_free: out_free, req: req_q};

  sbts_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .idle_o   (seq_idle)
  );

  // Route divider operands for the align and split divisions
  assign div_start = (ctrl.op == sbts_pkg::OP_DIV_ALIGN) || (ctrl.op == sbts_pkg::OP_DIV_SPLIT);
  assign div_a     = (ctrl.op == sbts_pkg::OP_DIV_ALIGN) ? now_q : sync_q;
  assign div_b     = (ctrl.op == sbts_pkg::OP_DIV_ALIGN) ? len_q : tps_q;

  sbts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .busy_o      (div_busy),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  // Configuration writes; hold the buffer length registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q  <= sbts_pkg::TpsReset;
      tpsm_q <= sbts_pkg::TpsmReset;
      td_q   <= sbts_pkg::TdReset;
      len_q  <= BufSize * {16'd0, sbts_pkg::TpsmReset};
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sbts_pkg::CfgTicksPerSecond: tps_q  <= cfg_data_i;
          sbts_pkg::CfgTicksPerSample: tpsm_q <= cfg_data_i[15:0];
          sbts_pkg::CfgTriggerDelay:   td_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      len_q <= BufSize * {16'd0, tpsm_q};
    end
  end

  assign full_pos = BufSize - {{(W-PosW){1'b0}}, rem_q};

  // Buffer start time, updated by start and buffer-complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_sec_q   <= '0;
      start_ticks_q <= '0;
    end else begin
      case (ctrl.op)
        sbts_pkg::OP_SPLIT: begin
          if (tps_q == '0) begin
            start_sec_q   <= '0;
            start_ticks_q <= sync_q;
          end else begin
            start_sec_q   <= div_q;
            start_ticks_q <= div_r;
          end
        end
        sbts_pkg::OP_BUF_WRAP: begin
          if (acc_q >= tps_q) begin
            start_ticks_q <= acc_q - tps_q;
            start_sec_q   <= start_sec_q + 1'b1;
          end else begin
            start_ticks_q <= acc_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath steps driven by the control word
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      sbts_pkg::OP_CAPTURE: begin
        if (accept) begin
          req_q <= req_type_i;
          now_q <= counter_now_i;
          rem_q <= dma_remaining_i;
        end
      end
      sbts_pkg::OP_CLR: begin
        sync_q <= '0;
        pos_q  <= '0;
        tsec_q <= '0;
        ttk_q  <= '0;
      end
      sbts_pkg::OP_SYNC: begin
        // align down to a buffer boundary, then two buffer lengths ahead
        sync_q <= ((len_q == '0) ? '0 : (now_q - div_r)) + {len_q[W-2:0], 1'b0};
      end
      sbts_pkg::OP_BUF_ADD: begin
        acc_q <= start_ticks_q + len_q;
      end
      sbts_pkg::OP_POS: begin
        pos_q <= full_pos[PosW-1:0];
        acc_q <= full_pos - {16'd0, td_q};
      end
      sbts_pkg::OP_MUL: begin
        acc_q <= acc_q * {16'd0, tpsm_q};
      end
      sbts_pkg::OP_TADD: begin
        ttk_q  <= start_ticks_q + acc_q;
        tsec_q <= start_sec_q;
      end
      sbts_pkg::OP_TNEG: begin
        // borrow a second when the trigger falls before the second
        if (ttk_q[W-1]) begin
          ttk_q  <= ttk_q + tps_q;
          tsec_q <= tsec_q - 1'b1;
        end
      end
      sbts_pkg::OP_TPOS: begin
        // carry a second when the trigger lands past it
        if ($signed(ttk_q) >= $signed(tps_q)) begin
          ttk_q  <= ttk_q - tps_q;
          tsec_q <= tsec_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl.op == sbts_pkg::OP_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if ((ctrl.op == sbts_pkg::OP_EMIT) && out_free) begin
      o_sync_q <= sync_q;
      o_bsec_q <= start_sec_q;
      o_btk_q  <= start_ticks_q;
      o_pos_q  <= pos_q;
      o_tsec_q <= tsec_q;
      o_ttk_q  <= ttk_q;
    end
  end

  assign in_stall_o      = !seq_idle;
  assign out_valid_o     = out_valid_q;
  assign sync_tick_o     = o_sync_q;
  assign buf_seconds_o   = o_bsec_q;
  assign buf_ticks_o     = o_btk_q;
  assign stop_position_o = o_pos_q;
  assign trig_seconds_o  = o_tsec_q;
  assign trig_ticks_o    = $signed(o_ttk_q);

  // Checks
  `SBTS_ASSERT_NEVER(a_no_accept_in_div, div_busy && !in_stall_o, "beat taken while dividing")
  `SBTS_ASSERT(a_div_wait, div_busy |-> (ctrl.cond == sbts_pkg::C_DIVBUSY), "divider runs unwatched")
  `SBTS_ASSERT(a_accept_clr, (in_valid_i && !in_stall_o) |=> (ctrl.op == sbts_pkg::OP_CLR), "no dispatch after beat")
  `SBTS_ASSERT(a_start_upd, !$stable(start_ticks_q) |-> ($past(ctrl.op) == sbts_pkg::OP_SPLIT || $past(ctrl.op) == sbts_pkg::OP_BUF_WRAP), "start time changed outside an event")

endmodule
